// ===== sv/sfd_pkg.sv =====
// Shared constants and types of the sum-check frame deframer.
`default_nettype none

package sfd_pkg;

	// Frame marker bytes.
	localparam logic [7:0] HDR0     = 8'hBB;
	localparam logic [7:0] HDR1     = 8'h10;
	localparam logic [7:0] HDR2     = 8'hF1;
	localparam logic [7:0] END_MARK = 8'hEE;
	localparam logic [7:0] EXT_FUNC = 8'h30;

	// Frame lengths and defaults.
	localparam logic [7:0]  BASIC_LEN     = 8'd8;
	localparam logic [7:0]  EXT_OVERHEAD  = 8'd9;
	localparam logic [7:0]  PAYLOAD_START = 8'd6;
	localparam logic [15:0] TIMEOUT_RESET = 16'd100;

	// Input kinds carried on s_tuser.
	localparam logic OP_BYTE = 1'b0;
	localparam logic OP_TICK = 1'b1;

	// Width of the packed result word.
	localparam int TDATA_W = 40;

	// A finished good frame, handed from the parser to the drain.
	typedef struct packed {
		logic       valid;
		logic [7:0] func;
		logic [7:0] sub;
		logic [7:0] len;
	} sfd_frame_t;

endpackage

`default_nettype wire

// ===== sv/sum_check_frame_deframer.sv =====
// Top level of the sum-check frame deframer.
//
//  Channel   Dir  Fields
//  cfg       in   cfg_we, cfg_wdata = timeout_ticks
//  s_axis    in   s_tdata = rx_byte, s_tuser = operation
//  m_axis    out  m_tdata = function_code..payload_byte, m_tuser = has_payload,
//                 m_tlast = last
//
// Bytes and ticks are taken one per cycle while no result run is pending.
// A good frame then holds the input while its run drains: each result word
// takes a payload memory read and then an output state; a frame with an
// empty payload gives one result word and no read. m_tready low stretches
// the output state.
// Reset is asynchronous and clears all control state; the payload store has
// no reset and no clearing pass.
`default_nettype none

module sum_check_frame_deframer #(
	parameter int MAX_PAYLOAD = 64
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [15:0]                   cfg_wdata,
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	input  wire logic [7:0]                    s_tdata,   // rx_byte
	input  wire logic [0:0]                    s_tuser,   // operation
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	// function_code, sub_code, payload_length, payload_position, payload_byte, 0
	output logic      [sfd_pkg::TDATA_W-1:0]   m_tdata,
	output logic      [0:0]                    m_tuser,   // has_payload
	output logic                               m_tlast
);

	import sfd_pkg::*;

	localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

	logic          in_fire;
	logic          busy;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	logic [7:0]    wr_data;
	logic          rd_en;
	logic [AW-1:0] rd_addr;
	logic [7:0]    rd_data;
	sfd_frame_t    frame;

	// Input words wait while a run drains.
	assign s_tready = !busy;
	assign in_fire  = s_tvalid && s_tready;

	sfd_parser #(
		.MAX_PAYLOAD (MAX_PAYLOAD),
		.AW          (AW)
	) u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_fire   (in_fire),
		.in_op     (s_tuser[0]),
		.in_byte   (s_tdata),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data),
		.frame     (frame)
	);

	sfd_payload_mem #(
		.DEPTH (MAX_PAYLOAD),
		.AW    (AW)
	) u_mem (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	sfd_drain #(
		.AW (AW)
	) u_drain (
		.clk      (clk),
		.arst_n   (arst_n),
		.frame    (frame),
		.rd_data  (rd_data),
		.rd_en    (rd_en),
		.rd_addr  (rd_addr),
		.busy     (busy),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule

`default_nettype wire

// ===== sv/sfd_payload_mem.sv =====
// Payload byte store: one write port and one registered read port.
`default_nettype none

module sfd_payload_mem #(
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  wire logic          clk,
	input  wire logic          wr_en,
	input  wire logic [AW-1:0] wr_addr,
	input  wire logic [7:0]    wr_data,
	input  wire logic          rd_en,
	input  wire logic [AW-1:0] rd_addr,
	output logic      [7:0]    rd_data
);

	logic [7:0] mem_q [DEPTH];
	logic [7:0] rd_data_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Registered read port; data holds until the next read.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

// ===== sv/sfd_parser.sv =====
// Frame parser: header hunt, timeout, checksums and payload writes.
`default_nettype none

module sfd_parser #(
	parameter int MAX_PAYLOAD = 64,
	parameter int AW          = 6
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire logic [15:0]        cfg_wdata,
	input  wire logic               in_fire,
	input  wire logic               in_op,
	input  wire logic [7:0]         in_byte,
	output logic                    wr_en,
	output logic      [AW-1:0]      wr_addr,
	output logic      [7:0]         wr_data,
	output sfd_pkg::sfd_frame_t     frame
);

	import sfd_pkg::*;

	localparam logic [7:0] MAX_LEN = 8'(MAX_PAYLOAD);

	logic [15:0] timeout_q;
	logic [7:0]  pos_q, pos_d;
	logic [7:0]  exp_q, exp_d;
	logic [16:0] idle_q, idle_d;
	logic [7:0]  sc_q, sc_d;
	logic [7:0]  ac_q, ac_d;
	logic        ok_q, ok_d;
	logic [7:0]  func_q, func_d;
	logic [7:0]  sub_q, sub_d;
	logic [7:0]  len_q, len_d;
	logic        timed_out;

	// Timeout register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TIMEOUT_RESET;
		end else if (cfg_we) begin
			timeout_q <= cfg_wdata;
		end
	end

	assign timed_out = (pos_q != 8'd0) && (idle_q > {1'b0, timeout_q});

	// Next-state logic for one byte or tick.
	always_comb begin
		logic [7:0] pos_c;
		logic [7:0] exp_c;
		logic [7:0] p;
		logic [7:0] pnext;
		logic [7:0] func_c;
		logic [7:0] len_c;
		logic [7:0] exp_n;
		logic       ok_c;

		pos_d   = pos_q;
		exp_d   = exp_q;
		idle_d  = idle_q;
		sc_d    = sc_q;
		ac_d    = ac_q;
		ok_d    = ok_q;
		func_d  = func_q;
		sub_d   = sub_q;
		len_d   = len_q;
		wr_en   = 1'b0;
		wr_addr = '0;
		wr_data = in_byte;
		frame   = '0;
		pos_c   = timed_out ? 8'd0 : pos_q;
		exp_c   = timed_out ? 8'd0 : exp_q;
		p       = pos_c;
		pnext   = pos_c + 8'd1;
		func_c  = (pos_c == 8'd3) ? in_byte : func_q;
		len_c   = len_q;
		exp_n   = exp_c;
		ok_c    = ok_q;

		if (in_fire && in_op == OP_TICK) begin
			if (idle_q != '1) begin
				idle_d = idle_q + 17'd1;
			end
		end else if (in_fire) begin
			idle_d = '0;
			pos_d  = pos_c;
			exp_d  = exp_c;
			if (pos_c == 8'd0 ||
			    (pos_c == 8'd1 && in_byte != HDR1) ||
			    (pos_c == 8'd2 && in_byte != HDR2)) begin
				// Hunting, or a header byte missed: resynchronize.
				if (in_byte == HDR0) begin
					pos_d = 8'd1;
					exp_d = 8'd0;
					sc_d  = HDR0;
					ac_d  = HDR0;
					ok_d  = 1'b1;
				end else begin
					pos_d = 8'd0;
				end
			end else begin
				pos_d  = pnext;
				func_d = func_c;
				if (p == 8'd4) begin
					sub_d = in_byte;
				end
				if (pnext == 8'd4 && func_c != EXT_FUNC) begin
					exp_n = BASIC_LEN;
					len_c = 8'd0;
				end else if (pnext == 8'd6 && func_c == EXT_FUNC &&
				             in_byte <= MAX_LEN) begin
					len_c = in_byte;
					exp_n = EXT_OVERHEAD + in_byte;
				end

				if (pnext == 8'd6 && func_c == EXT_FUNC && in_byte > MAX_LEN) begin
					// Oversized length: drop the frame.
					pos_d = 8'd0;
					exp_d = 8'd0;
				end else begin
					len_d = len_c;
					exp_d = exp_n;

					// Payload bytes go to the store.
					if (p >= PAYLOAD_START && func_c == EXT_FUNC &&
					    p < PAYLOAD_START + len_c) begin
						wr_en   = 1'b1;
						wr_addr = AW'(p - PAYLOAD_START);
					end

					// End byte and check bytes.
					if (exp_n >= 8'd3) begin
						if (p == exp_n - 8'd3) begin
							ok_c = ok_q && (in_byte == END_MARK);
						end else if (p == exp_n - 8'd2) begin
							ok_c = ok_q && (in_byte == sc_q);
						end else if (p == exp_n - 8'd1) begin
							ok_c = ok_q && (in_byte == ac_q);
						end
					end
					ok_d = ok_c;

					// Running sum and sum of sums.
					if (p < 8'd6 || (exp_n >= 8'd2 && p < exp_n - 8'd2)) begin
						sc_d = sc_q + in_byte;
						ac_d = ac_q + sc_q + in_byte;
					end

					// Frame complete.
					if (exp_n != 8'd0 && pnext >= exp_n) begin
						pos_d       = 8'd0;
						exp_d       = 8'd0;
						frame.valid = ok_c;
						frame.func  = func_c;
						frame.sub   = sub_d;
						frame.len   = len_c;
					end
				end
			end
		end
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= 8'd0;
			exp_q  <= 8'd0;
			idle_q <= '0;
			sc_q   <= 8'd0;
			ac_q   <= 8'd0;
			ok_q   <= 1'b0;
			func_q <= 8'd0;
			sub_q  <= 8'd0;
			len_q  <= 8'd0;
		end else begin
			pos_q  <= pos_d;
			exp_q  <= exp_d;
			idle_q <= idle_d;
			sc_q   <= sc_d;
			ac_q   <= ac_d;
			ok_q   <= ok_d;
			func_q <= func_d;
			sub_q  <= sub_d;
			len_q  <= len_d;
		end
	end

`ifndef SYNTH
	// Once the length is known, the position stays below it.
	a_pos_below_len: assert property (@(posedge clk) disable iff (!arst_n)
		exp_q != 8'd0 |-> pos_q < exp_q)
		else $error("frame position reached the frame length");

	// Payload writes stay inside the announced payload.
	a_wr_in_payload: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (8'(wr_addr) < len_d && len_d <= MAX_LEN))
		else $error("payload write outside the payload");

	// A reported frame restarts the hunt.
	a_done_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		frame.valid |=> pos_q == 8'd0 && exp_q == 8'd0)
		else $error("frame reported without returning to the hunt");
`endif

endmodule

`default_nettype wire

// ===== sv/sfd_drain.sv =====
// Result drain: reads the payload store and presents one result word at a time.
`default_nettype none

module sfd_drain #(
	parameter int AW = 6
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire sfd_pkg::sfd_frame_t           frame,
	input  wire logic [7:0]                    rd_data,
	output logic                               rd_en,
	output logic      [AW-1:0]                 rd_addr,
	output logic                               busy,
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	output logic      [sfd_pkg::TDATA_W-1:0]   m_tdata,
	output logic      [0:0]                    m_tuser,
	output logic                               m_tlast
);

	import sfd_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_READ = 3'b010,
		ST_OUT  = 3'b100
	} drain_state_t;

	drain_state_t    state_q, state_d;
	logic [AW-1:0]   idx_q;
	logic [7:0]      func_q;
	logic [7:0]      sub_q;
	logic [7:0]      len_q;
	logic            has_q;
	logic [7:0]      idx8;
	logic            last;

	assign idx8 = 8'(idx_q);
	assign last = !has_q || (idx8 + 8'd1 == len_q);

	// Sequencer: one memory read, then one result word; an empty payload gives its word with no read.
	always_comb begin
		state_d = state_q;
		rd_en   = 1'b0;
		rd_addr = '0;
		case (state_q)
			ST_IDLE: begin
				if (frame.valid) begin
					if (frame.len == 8'd0) begin
						state_d = ST_OUT;
					end else begin
						rd_en   = 1'b1;
						state_d = ST_READ;
					end
				end
			end
			ST_READ: begin
				state_d = ST_OUT;
			end
			ST_OUT: begin
				if (m_tready) begin
					if (last) begin
						state_d = ST_IDLE;
					end else begin
						rd_en   = 1'b1;
						rd_addr = AW'(idx_q + 1'b1);
						state_d = ST_READ;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Frame header fields and word index.
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && frame.valid) begin
			func_q <= frame.func;
			sub_q  <= frame.sub;
			len_q  <= frame.len;
			has_q  <= frame.len != 8'd0;
			idx_q  <= '0;
		end else if (state_q == ST_OUT && m_tready && !last) begin
			idx_q <= AW'(idx_q + 1'b1);
		end
	end

	// Result word.
	assign busy     = state_q != ST_IDLE;
	assign m_tvalid = state_q == ST_OUT;
	assign m_tlast  = last;
	assign m_tuser  = has_q;
	assign m_tdata  = {3'b000,
	                   has_q ? rd_data : 8'd0,
	                   idx8[5:0],
	                   len_q[6:0],
	                   sub_q,
	                   func_q};

`ifndef SYNTH
	// The parser only reports a frame while the drain is free.
	a_frame_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		frame.valid |-> state_q == ST_IDLE)
		else $error("frame reported while a run is still draining");

	// Every read state follows a read request.
	a_read_issued: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_READ |-> $past(rd_en))
		else $error("read state without a memory read");

	// The word index never passes the payload length.
	a_idx_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT && has_q) |-> idx8 < len_q)
		else $error("payload index beyond payload length");
`endif

endmodule

`default_nettype wire
